/* src/bts_pkg.sv */
// ----------------------------------------------------------------------------
// bts_pkg
// Types, codes and the transition table of the bus transfer sequencer.
// ----------------------------------------------------------------------------
package bts_pkg;

  // fixed field widths
  localparam int unsigned REQ_W     = 4;
  localparam int unsigned ADDR_W    = 7;
  localparam int unsigned STALL_W   = 16;
  localparam int unsigned TIMEOUT_W = 32;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned KIND_W    = 3;
  localparam int unsigned SCODE_W   = 3;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_W     = 32;

  // reset value of the stall limit
  localparam logic [STALL_W-1:0] STUCK_LIMIT_RST = STALL_W'(300);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STUCK_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLK_TIMEOUT = 1'b1;

  // request codes
  localparam logic [REQ_W-1:0] REQ_TICK      = 4'd0;
  localparam logic [REQ_W-1:0] REQ_DMA_READ  = 4'd1;
  localparam logic [REQ_W-1:0] REQ_DMA_WRITE = 4'd2;
  localparam logic [REQ_W-1:0] REQ_DMA_WR_RD = 4'd3;
  localparam logic [REQ_W-1:0] REQ_DONE_ACK  = 4'd4;
  localparam logic [REQ_W-1:0] REQ_START_REF = 4'd5;
  localparam logic [REQ_W-1:0] REQ_CLEAR_EV  = 4'd6;
  localparam logic [REQ_W-1:0] REQ_BLK_READ  = 4'd7;
  localparam logic [REQ_W-1:0] REQ_BLK_WRITE = 4'd8;

  // status codes
  localparam logic [STATUS_W-1:0] STAT_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_FREE     = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_BUSY     = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_ERR_ST   = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_ERR_IDLE = 3'd4;

  // command kinds
  localparam logic [KIND_W-1:0] CMD_NONE      = 3'd0;
  localparam logic [KIND_W-1:0] CMD_REINIT    = 3'd1;
  localparam logic [KIND_W-1:0] CMD_DMA_READ  = 3'd2;
  localparam logic [KIND_W-1:0] CMD_DMA_WRITE = 3'd3;
  localparam logic [KIND_W-1:0] CMD_BLK_READ  = 3'd4;
  localparam logic [KIND_W-1:0] CMD_BLK_WRITE = 3'd5;

  // state codes as reported on the result channel
  localparam logic [SCODE_W-1:0] SC_IDLE  = 3'd0;
  localparam logic [SCODE_W-1:0] SC_INIT  = 3'd1;
  localparam logic [SCODE_W-1:0] SC_DRD   = 3'd2;
  localparam logic [SCODE_W-1:0] SC_DWR   = 3'd3;
  localparam logic [SCODE_W-1:0] SC_BRD   = 3'd4;
  localparam logic [SCODE_W-1:0] SC_BWR   = 3'd5;
  localparam logic [SCODE_W-1:0] SC_ERROR = 3'd6;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_INIT  = 7'b0000010,
    S_DRD   = 7'b0000100,
    S_DWR   = 7'b0001000,
    S_BRD   = 7'b0010000,
    S_BWR   = 7'b0100000,
    S_ERROR = 7'b1000000
  } state_t;

  typedef enum logic [3:0] {
    E_NONE         = 4'd0,
    E_INIT_DONE    = 4'd1,
    E_DRD_DONE     = 4'd2,
    E_DWR_DONE     = 4'd3,
    E_WR_PART_DONE = 4'd4,
    E_BRD_DONE     = 4'd5,
    E_BWR_DONE     = 4'd6,
    E_DRD          = 4'd7,
    E_DWR          = 4'd8,
    E_DWRRD        = 4'd9,
    E_BRD          = 4'd10,
    E_BWR          = 4'd11,
    E_ERROR        = 4'd12
  } event_t;

  typedef struct packed {
    logic   hit;
    state_t to;
  } trans_t;

  // transition table: (state, event) -> next state
  function automatic trans_t lookup(input state_t st, input event_t ev);
    trans_t t;
    t.hit = 1'b1;
    t.to  = st;
    unique case (st)
      S_INIT: begin
        case (ev)
          E_INIT_DONE: t.to = S_IDLE;
          E_ERROR:     t.to = S_ERROR;
          E_NONE:      t.to = S_INIT;
          default:     t.hit = 1'b0;
        endcase
      end
      S_DRD: begin
        case (ev)
          E_DRD_DONE: t.to = S_IDLE;
          E_ERROR:    t.to = S_ERROR;
          default:    t.hit = 1'b0;
        endcase
      end
      S_DWR: begin
        case (ev)
          E_DWR_DONE:     t.to = S_IDLE;
          E_WR_PART_DONE: t.to = S_DRD;
          E_ERROR:        t.to = S_ERROR;
          default:        t.hit = 1'b0;
        endcase
      end
      S_BRD: begin
        case (ev)
          E_BRD_DONE: t.to = S_IDLE;
          E_ERROR:    t.to = S_ERROR;
          default:    t.hit = 1'b0;
        endcase
      end
      S_BWR: begin
        case (ev)
          E_BWR_DONE: t.to = S_IDLE;
          E_ERROR:    t.to = S_ERROR;
          default:    t.hit = 1'b0;
        endcase
      end
      S_IDLE: begin
        case (ev)
          E_DRD:   t.to = S_DRD;
          E_DWR:   t.to = S_DWR;
          E_DWRRD: t.to = S_DWR;
          E_BRD:   t.to = S_BRD;
          E_BWR:   t.to = S_BWR;
          E_NONE:  t.to = S_IDLE;
          default: t.hit = 1'b0;
        endcase
      end
      S_ERROR: begin
        case (ev)
          E_NONE:  t.to = S_IDLE;
          default: t.hit = 1'b0;
        endcase
      end
      default: t.hit = 1'b0;
    endcase
    return t;
  endfunction

  // one-hot state to its reported code
  function automatic logic [SCODE_W-1:0] state_code(input state_t st);
    logic [SCODE_W-1:0] c;
    unique case (st)
      S_IDLE:  c = SC_IDLE;
      S_INIT:  c = SC_INIT;
      S_DRD:   c = SC_DRD;
      S_DWR:   c = SC_DWR;
      S_BRD:   c = SC_BRD;
      S_BWR:   c = SC_BWR;
      S_ERROR: c = SC_ERROR;
      default: c = SC_IDLE;
    endcase
    return c;
  endfunction

endpackage

/* src/bus_transfer_sequencer.sv */
// ----------------------------------------------------------------------------
// bus_transfer_sequencer
// Transfer sequencer for a two-wire bus master: request handling, tick-driven
// transition table, start commands and a stall watchdog.
// ----------------------------------------------------------------------------
//
//  channel  handshake              payload
//  in_      in_valid / in_stall    req_type, dev_address, transfer_length,
//                                  read_back_length
//  out_     out_valid / out_stall  status, accepted, cmd_*, watchdog_fired,
//                                  state_now
//  cfg_     cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  One request is taken per cycle while in_stall is low; its result appears in
//  the output register in the cycle after acceptance, set by the single pass
//  through the table lookup and stall counter update.
//  Reset (rst_n low, synchronous) puts the controller in init with no event,
//  clears the stall counter and empties the output register.
//  in_stall is raised only while a result is held and out_stall is high.
//  cfg_ready is always high.
//
module bus_transfer_sequencer #(
  parameter int unsigned LENGTH_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // request channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [bts_pkg::REQ_W-1:0]            in_req_type,
  input  logic [bts_pkg::ADDR_W-1:0]           in_dev_address,
  input  logic [LENGTH_BITS-1:0]               in_transfer_length,
  input  logic [LENGTH_BITS-1:0]               in_read_back_length,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [bts_pkg::STATUS_W-1:0]         out_status,
  output logic                                 out_accepted,
  output logic                                 out_cmd_valid,
  output logic [bts_pkg::KIND_W-1:0]           out_cmd_kind,
  output logic [bts_pkg::ADDR_W-1:0]           out_cmd_address,
  output logic [LENGTH_BITS-1:0]               out_cmd_length,
  output logic [bts_pkg::TIMEOUT_W-1:0]        out_cmd_timeout,
  output logic                                 out_watchdog_fired,
  output logic [bts_pkg::SCODE_W-1:0]          out_state_now,
  // configuration channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [bts_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [bts_pkg::CFG_W-1:0]            cfg_data
);

  // configuration registers
  logic [bts_pkg::STALL_W-1:0]   stuck_limit_r;
  logic [bts_pkg::TIMEOUT_W-1:0] blk_timeout_r;

  // controller state
  bts_pkg::state_t               state_r,   state_nxt;
  bts_pkg::event_t               event_r,   event_nxt;
  logic [bts_pkg::STALL_W-1:0]   stall_r,   stall_nxt;
  logic [bts_pkg::ADDR_W-1:0]    addr_r,    addr_nxt;
  logic [LENGTH_BITS-1:0]        wr_len_r,  wr_len_nxt;
  logic [LENGTH_BITS-1:0]        rd_len_r,  rd_len_nxt;

  // tick intermediates
  logic [bts_pkg::STALL_W:0]     stall_sum;
  bts_pkg::state_t               tick_state;
  bts_pkg::event_t               tick_event;
  bts_pkg::trans_t               trans;

  // result of this request
  logic                          acc_c;
  logic                          cmd_valid_c;
  logic [bts_pkg::KIND_W-1:0]    cmd_kind_c;
  logic [bts_pkg::ADDR_W-1:0]    cmd_addr_c;
  logic [LENGTH_BITS-1:0]        cmd_len_c;
  logic [bts_pkg::TIMEOUT_W-1:0] cmd_time_c;
  logic                          wd_c;
  logic [bts_pkg::STATUS_W-1:0]  status_c;

  // output register
  logic                          out_valid_r;
  logic [bts_pkg::STATUS_W-1:0]  status_r;
  logic                          accepted_r;
  logic                          cmd_valid_r;
  logic [bts_pkg::KIND_W-1:0]    cmd_kind_r;
  logic [bts_pkg::ADDR_W-1:0]    cmd_addr_r;
  logic [LENGTH_BITS-1:0]        cmd_len_r;
  logic [bts_pkg::TIMEOUT_W-1:0] cmd_time_r;
  logic                          wd_r;
  logic [bts_pkg::SCODE_W-1:0]   state_code_r;

  logic                          in_acc;

  // handshakes
  assign in_stall  = out_valid_r & out_stall;
  assign in_acc    = in_valid & ~in_stall;
  assign cfg_ready = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stuck_limit_r <= bts_pkg::STUCK_LIMIT_RST;
      blk_timeout_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bts_pkg::CFG_STUCK_LIMIT: stuck_limit_r <= cfg_data[bts_pkg::STALL_W-1:0];
        bts_pkg::CFG_BLK_TIMEOUT: blk_timeout_r <= cfg_data[bts_pkg::TIMEOUT_W-1:0];
        default: ;
      endcase
    end
  end

  // request decode, watchdog and table step
  always_comb begin
    state_nxt   = state_r;
    event_nxt   = event_r;
    stall_nxt   = stall_r;
    addr_nxt    = addr_r;
    wr_len_nxt  = wr_len_r;
    rd_len_nxt  = rd_len_r;
    stall_sum   = {1'b0, stall_r} + {{bts_pkg::STALL_W{1'b0}}, 1'b1};
    tick_state  = state_r;
    tick_event  = event_r;
    trans       = bts_pkg::lookup(tick_state, tick_event);
    acc_c       = 1'b0;
    cmd_valid_c = 1'b0;
    cmd_kind_c  = bts_pkg::CMD_NONE;
    cmd_addr_c  = '0;
    cmd_len_c   = '0;
    cmd_time_c  = '0;
    wd_c        = 1'b0;

    unique case (in_req_type)
      bts_pkg::REQ_TICK: begin
        // stall watchdog forces init with an error pending
        if (stall_sum > {1'b0, stuck_limit_r}) begin
          tick_state = bts_pkg::S_INIT;
          tick_event = bts_pkg::E_ERROR;
          stall_nxt  = '0;
          wd_c       = 1'b1;
        end else begin
          stall_nxt  = stall_sum[bts_pkg::STALL_W-1:0];
        end
        trans     = bts_pkg::lookup(tick_state, tick_event);
        state_nxt = tick_state;
        event_nxt = tick_event;
        if (trans.hit) begin
          stall_nxt = '0;
          state_nxt = trans.to;
          // entry actions of the new state
          unique case (trans.to)
            bts_pkg::S_INIT: begin
              cmd_valid_c = 1'b1;
              cmd_kind_c  = bts_pkg::CMD_REINIT;
              state_nxt   = bts_pkg::S_IDLE;
              event_nxt   = bts_pkg::E_INIT_DONE;
            end
            bts_pkg::S_DRD: begin
              cmd_valid_c = 1'b1;
              cmd_kind_c  = bts_pkg::CMD_DMA_READ;
              cmd_addr_c  = addr_r;
              cmd_len_c   = rd_len_r;
            end
            bts_pkg::S_DWR: begin
              cmd_valid_c = 1'b1;
              cmd_kind_c  = bts_pkg::CMD_DMA_WRITE;
              cmd_addr_c  = addr_r;
              cmd_len_c   = wr_len_r;
            end
            bts_pkg::S_BRD: begin
              cmd_valid_c = 1'b1;
              cmd_kind_c  = bts_pkg::CMD_BLK_READ;
              cmd_addr_c  = addr_r;
              cmd_len_c   = rd_len_r;
              cmd_time_c  = blk_timeout_r;
            end
            bts_pkg::S_BWR: begin
              cmd_valid_c = 1'b1;
              cmd_kind_c  = bts_pkg::CMD_BLK_WRITE;
              cmd_addr_c  = addr_r;
              cmd_len_c   = wr_len_r;
              cmd_time_c  = blk_timeout_r;
            end
            bts_pkg::S_ERROR: event_nxt = bts_pkg::E_NONE;
            bts_pkg::S_IDLE:  ;
            default: ;
          endcase
        end
      end
      bts_pkg::REQ_DMA_READ, bts_pkg::REQ_BLK_READ: begin
        // single-direction read latches a write length of one
        if (state_r == bts_pkg::S_IDLE) begin
          addr_nxt   = in_dev_address;
          wr_len_nxt = LENGTH_BITS'(1);
          rd_len_nxt = in_transfer_length;
          event_nxt  = (in_req_type == bts_pkg::REQ_DMA_READ) ? bts_pkg::E_DRD
                                                              : bts_pkg::E_BRD;
          acc_c      = 1'b1;
        end
      end
      bts_pkg::REQ_DMA_WRITE, bts_pkg::REQ_BLK_WRITE: begin
        // single-direction write latches a read length of one
        if (state_r == bts_pkg::S_IDLE) begin
          addr_nxt   = in_dev_address;
          wr_len_nxt = in_transfer_length;
          rd_len_nxt = LENGTH_BITS'(1);
          event_nxt  = (in_req_type == bts_pkg::REQ_DMA_WRITE) ? bts_pkg::E_DWR
                                                               : bts_pkg::E_BWR;
          acc_c      = 1'b1;
        end
      end
      bts_pkg::REQ_DMA_WR_RD: begin
        if (state_r == bts_pkg::S_IDLE) begin
          addr_nxt   = in_dev_address;
          wr_len_nxt = in_transfer_length;
          rd_len_nxt = in_read_back_length;
          event_nxt  = bts_pkg::E_DWRRD;
          acc_c      = 1'b1;
        end
      end
      bts_pkg::REQ_DONE_ACK: begin
        // completion only counts in a transfer state
        unique case (state_r)
          bts_pkg::S_DRD: event_nxt = bts_pkg::E_DRD_DONE;
          bts_pkg::S_DWR: event_nxt = (event_r == bts_pkg::E_DWRRD) ?
                                      bts_pkg::E_WR_PART_DONE : bts_pkg::E_DWR_DONE;
          bts_pkg::S_BRD: event_nxt = bts_pkg::E_BRD_DONE;
          bts_pkg::S_BWR: event_nxt = bts_pkg::E_BWR_DONE;
          default: ;
        endcase
      end
      bts_pkg::REQ_START_REF: event_nxt = bts_pkg::E_ERROR;
      bts_pkg::REQ_CLEAR_EV:  event_nxt = bts_pkg::E_NONE;
      default: ;
    endcase
  end

  // status after the request
  always_comb begin
    if (state_nxt == bts_pkg::S_IDLE && event_nxt == bts_pkg::E_ERROR) begin
      status_c = bts_pkg::STAT_ERR_IDLE;
    end else if (state_nxt == bts_pkg::S_ERROR) begin
      status_c = bts_pkg::STAT_ERR_ST;
    end else if (state_nxt != bts_pkg::S_IDLE) begin
      status_c = bts_pkg::STAT_BUSY;
    end else if (event_nxt == bts_pkg::E_NONE || event_nxt == bts_pkg::E_INIT_DONE) begin
      status_c = bts_pkg::STAT_FREE;
    end else begin
      status_c = bts_pkg::STAT_OK;
    end
  end

  // controller state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= bts_pkg::S_INIT;
      event_r  <= bts_pkg::E_NONE;
      stall_r  <= '0;
      addr_r   <= '0;
      wr_len_r <= '0;
      rd_len_r <= '0;
    end else if (in_acc) begin
      state_r  <= state_nxt;
      event_r  <= event_nxt;
      stall_r  <= stall_nxt;
      addr_r   <= addr_nxt;
      wr_len_r <= wr_len_nxt;
      rd_len_r <= rd_len_nxt;
    end
  end

  // output register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      status_r     <= status_c;
      accepted_r   <= acc_c;
      cmd_valid_r  <= cmd_valid_c;
      cmd_kind_r   <= cmd_kind_c;
      cmd_addr_r   <= cmd_addr_c;
      cmd_len_r    <= cmd_len_c;
      cmd_time_r   <= cmd_time_c;
      wd_r         <= wd_c;
      state_code_r <= bts_pkg::state_code(state_nxt);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = status_r;
  assign out_accepted       = accepted_r;
  assign out_cmd_valid      = cmd_valid_r;
  assign out_cmd_kind       = cmd_kind_r;
  assign out_cmd_address    = cmd_addr_r;
  assign out_cmd_length     = cmd_len_r;
  assign out_cmd_timeout    = cmd_time_r;
  assign out_watchdog_fired = wd_r;
  assign out_state_now      = state_code_r;

`ifndef SYNTHESIS
  // an accepted request always produces a result next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid_r)
    else $error("accepted request produced no result");

  // an issued command always carries a kind
  a_cmd_has_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && cmd_valid_r) |-> (cmd_kind_r != bts_pkg::CMD_NONE))
    else $error("command issued without a kind");

  // watchdog always lands in the error state without a command
  a_wd_to_error: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && wd_r) |-> (state_code_r == bts_pkg::SC_ERROR && !cmd_valid_r))
    else $error("watchdog did not end in error state");

  // a taken request leaves the controller idle
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && accepted_r) |-> (state_code_r == bts_pkg::SC_IDLE))
    else $error("request taken outside idle");
`endif

endmodule

/* verif/bus_transfer_sequencer_tb.sv */
// ----------------------------------------------------------------------------
// bus_transfer_sequencer_tb
// Self-checking bench for the bus transfer sequencer. A scoreboard class keeps
// its own copy of the controller state, works out the status and start
// command of every accepted request, and compares them with the result channel.
// Directed requests walk every request code and transfer flow. Random phases
// run under several stall limits and timeouts with random idling on both
// channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bus_transfer_sequencer_tb;

  localparam int unsigned LEN_W = 16;

  typedef struct packed {
    logic [bts_pkg::REQ_W-1:0]  req_type;
    logic [bts_pkg::ADDR_W-1:0] dev_address;
    logic [LEN_W-1:0]           transfer_length;
    logic [LEN_W-1:0]           read_back_length;
  } request_t;

  typedef struct packed {
    logic [bts_pkg::STATUS_W-1:0]  status;
    logic                          accepted;
    logic                          cmd_valid;
    logic [bts_pkg::KIND_W-1:0]    cmd_kind;
    logic [bts_pkg::ADDR_W-1:0]    cmd_address;
    logic [LEN_W-1:0]              cmd_length;
    logic [bts_pkg::TIMEOUT_W-1:0] cmd_timeout;
    logic                          watchdog_fired;
    logic [bts_pkg::SCODE_W-1:0]   state_now;
  } report_t;

  // scoreboard: tracks the controller and queues the report each request should give
  class sequencer_tracker;
    logic [bts_pkg::STALL_W-1:0]   stuck_limit;
    logic [bts_pkg::TIMEOUT_W-1:0] blk_timeout;
    logic [bts_pkg::SCODE_W-1:0]   st;
    bts_pkg::event_t               ev;
    logic [bts_pkg::STALL_W-1:0]   stall_cnt;
    logic [bts_pkg::ADDR_W-1:0]    addr_l;
    logic [LEN_W-1:0]              wlen_l;
    logic [LEN_W-1:0]              rlen_l;
    report_t                       awaited_reports[$];
    int                            failures;

    function new();
      stuck_limit = bts_pkg::STUCK_LIMIT_RST;
      blk_timeout = '0;
      st          = bts_pkg::SC_INIT;
      ev          = bts_pkg::E_NONE;
      stall_cnt   = '0;
      addr_l      = '0;
      wlen_l      = '0;
      rlen_l      = '0;
      failures    = 0;
    endfunction

    function void set_reg(input logic [bts_pkg::CFG_IDX_W-1:0] idx,
                          input logic [bts_pkg::CFG_W-1:0] data);
      if (idx == bts_pkg::CFG_STUCK_LIMIT) stuck_limit = data[bts_pkg::STALL_W-1:0];
      else blk_timeout = data;
    endfunction

    function int outstanding();
      return awaited_reports.size();
    endfunction

    // (state, event) pairs that have a row, and where they lead
    function bit find_row(input logic [bts_pkg::SCODE_W-1:0] from, input bts_pkg::event_t e,
                          output logic [bts_pkg::SCODE_W-1:0] to);
      bit hit;
      hit = 1'b1;
      to  = from;
      case (from)
        bts_pkg::SC_INIT: begin
          if (e == bts_pkg::E_INIT_DONE) to = bts_pkg::SC_IDLE;
          else if (e == bts_pkg::E_ERROR) to = bts_pkg::SC_ERROR;
          else if (e != bts_pkg::E_NONE) hit = 1'b0;
        end
        bts_pkg::SC_DRD: begin
          if (e == bts_pkg::E_DRD_DONE) to = bts_pkg::SC_IDLE;
          else if (e == bts_pkg::E_ERROR) to = bts_pkg::SC_ERROR;
          else hit = 1'b0;
        end
        bts_pkg::SC_DWR: begin
          if (e == bts_pkg::E_DWR_DONE) to = bts_pkg::SC_IDLE;
          else if (e == bts_pkg::E_WR_PART_DONE) to = bts_pkg::SC_DRD;
          else if (e == bts_pkg::E_ERROR) to = bts_pkg::SC_ERROR;
          else hit = 1'b0;
        end
        bts_pkg::SC_BRD: begin
          if (e == bts_pkg::E_BRD_DONE) to = bts_pkg::SC_IDLE;
          else if (e == bts_pkg::E_ERROR) to = bts_pkg::SC_ERROR;
          else hit = 1'b0;
        end
        bts_pkg::SC_BWR: begin
          if (e == bts_pkg::E_BWR_DONE) to = bts_pkg::SC_IDLE;
          else if (e == bts_pkg::E_ERROR) to = bts_pkg::SC_ERROR;
          else hit = 1'b0;
        end
        bts_pkg::SC_IDLE: begin
          if (e == bts_pkg::E_DRD) to = bts_pkg::SC_DRD;
          else if (e == bts_pkg::E_DWR || e == bts_pkg::E_DWRRD) to = bts_pkg::SC_DWR;
          else if (e == bts_pkg::E_BRD) to = bts_pkg::SC_BRD;
          else if (e == bts_pkg::E_BWR) to = bts_pkg::SC_BWR;
          else if (e != bts_pkg::E_NONE) hit = 1'b0;
        end
        bts_pkg::SC_ERROR: begin
          if (e == bts_pkg::E_NONE) to = bts_pkg::SC_IDLE;
          else hit = 1'b0;
        end
        default: hit = 1'b0;
      endcase
      return hit;
    endfunction

    function void take_request(input request_t r);
      report_t                     x;
      logic [bts_pkg::SCODE_W-1:0] nxt;
      bit                          was_idle;
      x        = '0;
      was_idle = (st == bts_pkg::SC_IDLE);
      case (r.req_type)
        bts_pkg::REQ_TICK: begin
          // stall watchdog comes first, then the table
          if ({1'b0, stall_cnt} + 17'd1 > {1'b0, stuck_limit}) begin
            st               = bts_pkg::SC_INIT;
            ev               = bts_pkg::E_ERROR;
            stall_cnt        = '0;
            x.watchdog_fired = 1'b1;
          end else begin
            stall_cnt = stall_cnt + 1'b1;
          end
          if (find_row(st, ev, nxt)) begin
            st        = nxt;
            stall_cnt = '0;
            // entry actions of the new state
            case (st)
              bts_pkg::SC_INIT: begin
                x.cmd_valid = 1'b1;
                x.cmd_kind  = bts_pkg::CMD_REINIT;
                st          = bts_pkg::SC_IDLE;
                ev          = bts_pkg::E_INIT_DONE;
              end
              bts_pkg::SC_DRD: begin
                x.cmd_valid   = 1'b1;
                x.cmd_kind    = bts_pkg::CMD_DMA_READ;
                x.cmd_address = addr_l;
                x.cmd_length  = rlen_l;
              end
              bts_pkg::SC_DWR: begin
                x.cmd_valid   = 1'b1;
                x.cmd_kind    = bts_pkg::CMD_DMA_WRITE;
                x.cmd_address = addr_l;
                x.cmd_length  = wlen_l;
              end
              bts_pkg::SC_BRD: begin
                x.cmd_valid   = 1'b1;
                x.cmd_kind    = bts_pkg::CMD_BLK_READ;
                x.cmd_address = addr_l;
                x.cmd_length  = rlen_l;
                x.cmd_timeout = blk_timeout;
              end
              bts_pkg::SC_BWR: begin
                x.cmd_valid   = 1'b1;
                x.cmd_kind    = bts_pkg::CMD_BLK_WRITE;
                x.cmd_address = addr_l;
                x.cmd_length  = wlen_l;
                x.cmd_timeout = blk_timeout;
              end
              bts_pkg::SC_ERROR: ev = bts_pkg::E_NONE;
              default: ;
            endcase
          end
        end
        // transfer requests latch only in idle; single-direction sets the other length to one
        bts_pkg::REQ_DMA_READ, bts_pkg::REQ_BLK_READ, bts_pkg::REQ_DMA_WRITE,
        bts_pkg::REQ_BLK_WRITE, bts_pkg::REQ_DMA_WR_RD: begin
          if (was_idle) begin
            x.accepted = 1'b1;
            addr_l     = r.dev_address;
            case (r.req_type)
              bts_pkg::REQ_DMA_READ, bts_pkg::REQ_BLK_READ: begin
                wlen_l = LEN_W'(1);
                rlen_l = r.transfer_length;
              end
              bts_pkg::REQ_DMA_WR_RD: begin
                wlen_l = r.transfer_length;
                rlen_l = r.read_back_length;
              end
              default: begin
                wlen_l = r.transfer_length;
                rlen_l = LEN_W'(1);
              end
            endcase
            case (r.req_type)
              bts_pkg::REQ_DMA_READ:  ev = bts_pkg::E_DRD;
              bts_pkg::REQ_BLK_READ:  ev = bts_pkg::E_BRD;
              bts_pkg::REQ_DMA_WRITE: ev = bts_pkg::E_DWR;
              bts_pkg::REQ_BLK_WRITE: ev = bts_pkg::E_BWR;
              default:                ev = bts_pkg::E_DWRRD;
            endcase
          end
        end
        bts_pkg::REQ_DONE_ACK: begin
          if (st == bts_pkg::SC_DRD) ev = bts_pkg::E_DRD_DONE;
          else if (st == bts_pkg::SC_DWR)
            ev = (ev == bts_pkg::E_DWRRD) ? bts_pkg::E_WR_PART_DONE : bts_pkg::E_DWR_DONE;
          else if (st == bts_pkg::SC_BWR) ev = bts_pkg::E_BWR_DONE;
          else if (st == bts_pkg::SC_BRD) ev = bts_pkg::E_BRD_DONE;
        end
        bts_pkg::REQ_START_REF: ev = bts_pkg::E_ERROR;
        bts_pkg::REQ_CLEAR_EV:  ev = bts_pkg::E_NONE;
        default: ;
      endcase
      // status after the request
      if (st == bts_pkg::SC_IDLE && ev == bts_pkg::E_ERROR) x.status = bts_pkg::STAT_ERR_IDLE;
      else if (st == bts_pkg::SC_ERROR) x.status = bts_pkg::STAT_ERR_ST;
      else if (st != bts_pkg::SC_IDLE) x.status = bts_pkg::STAT_BUSY;
      else if (ev == bts_pkg::E_NONE || ev == bts_pkg::E_INIT_DONE)
        x.status = bts_pkg::STAT_FREE;
      else x.status = bts_pkg::STAT_OK;
      x.state_now = st;
      awaited_reports.push_back(x);
    endfunction

    function void compare(input string name, input logic [31:0] exp, input logic [31:0] act);
      if (exp !== act) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, exp, act);
        failures++;
      end
    endfunction

    function void check_result(input report_t got);
      report_t exp;
      if (awaited_reports.size() == 0) begin
        $error("result with no request waiting for it");
        failures++;
        return;
      end
      exp = awaited_reports.pop_front();
      compare("status", 32'(exp.status), 32'(got.status));
      compare("accepted", 32'(exp.accepted), 32'(got.accepted));
      compare("cmd_valid", 32'(exp.cmd_valid), 32'(got.cmd_valid));
      compare("cmd_kind", 32'(exp.cmd_kind), 32'(got.cmd_kind));
      compare("cmd_address", 32'(exp.cmd_address), 32'(got.cmd_address));
      compare("cmd_length", 32'(exp.cmd_length), 32'(got.cmd_length));
      compare("cmd_timeout", exp.cmd_timeout, got.cmd_timeout);
      compare("watchdog_fired", 32'(exp.watchdog_fired), 32'(got.watchdog_fired));
      compare("state_now", 32'(exp.state_now), 32'(got.state_now));
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [bts_pkg::REQ_W-1:0]     in_req_type = '0;
  logic [bts_pkg::ADDR_W-1:0]    in_dev_address = '0;
  logic [LEN_W-1:0]              in_transfer_length = '0;
  logic [LEN_W-1:0]              in_read_back_length = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [bts_pkg::STATUS_W-1:0]  out_status;
  logic                          out_accepted;
  logic                          out_cmd_valid;
  logic [bts_pkg::KIND_W-1:0]    out_cmd_kind;
  logic [bts_pkg::ADDR_W-1:0]    out_cmd_address;
  logic [LEN_W-1:0]              out_cmd_length;
  logic [bts_pkg::TIMEOUT_W-1:0] out_cmd_timeout;
  logic                          out_watchdog_fired;
  logic [bts_pkg::SCODE_W-1:0]   out_state_now;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [bts_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [bts_pkg::CFG_W-1:0]     cfg_data = '0;

  sequencer_tracker tracker = new();
  int sent_count = 0;
  int got_count = 0;

  bus_transfer_sequencer #(.LENGTH_BITS(LEN_W)) uut (.*);

  always #10 clk = ~clk;

  // idle draw: a random gap before each item, with every fourth stretch of 24 items free of gaps
  function automatic int pick_wait(input int count);
    return ((count / 24) % 4 == 3) ? 0 : int'($urandom_range(0, 11));
  endfunction

  function automatic logic [LEN_W-1:0] rand_len();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return LEN_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // one request through the input handshake
  task automatic send_item(input logic [bts_pkg::REQ_W-1:0] kind,
                           input logic [bts_pkg::ADDR_W-1:0] addr,
                           input logic [LEN_W-1:0] len, input logic [LEN_W-1:0] rb);
    request_t r;
    int       gap;
    r   = '{req_type: kind, dev_address: addr, transfer_length: len, read_back_length: rb};
    gap = pick_wait(sent_count);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_req_type         <= r.req_type;
    in_dev_address      <= r.dev_address;
    in_transfer_length  <= r.transfer_length;
    in_read_back_length <= r.read_back_length;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.take_request(r);
    sent_count++;
  endtask

  task automatic send_random(input logic [bts_pkg::REQ_W-1:0] kind);
    send_item(kind, bts_pkg::ADDR_W'($urandom_range(0, 127)), rand_len(), rand_len());
  endtask

  // occasional stray request inside a flow
  task automatic maybe_noise();
    if ($urandom_range(0, 5) == 0) send_random(bts_pkg::REQ_W'($urandom_range(0, 15)));
  endtask

  // well-formed transfer: request, start tick, done ack, closing tick (a second ack and tick for write-then-read)
  task automatic run_transfer();
    logic [bts_pkg::REQ_W-1:0] kind;
    case ($urandom_range(0, 4))
      0:       kind = bts_pkg::REQ_DMA_READ;
      1:       kind = bts_pkg::REQ_DMA_WRITE;
      2:       kind = bts_pkg::REQ_DMA_WR_RD;
      3:       kind = bts_pkg::REQ_BLK_READ;
      default: kind = bts_pkg::REQ_BLK_WRITE;
    endcase
    if ($urandom_range(0, 1)) send_random(bts_pkg::REQ_TICK);
    send_random(kind);
    maybe_noise();
    send_random(bts_pkg::REQ_TICK);
    maybe_noise();
    send_random(bts_pkg::REQ_DONE_ACK);
    send_random(bts_pkg::REQ_TICK);
    if (kind == bts_pkg::REQ_DMA_WR_RD) begin
      send_random(bts_pkg::REQ_DONE_ACK);
      send_random(bts_pkg::REQ_TICK);
    end
  endtask

  task automatic random_phase(input int target);
    int n;
    while (sent_count < target) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: run_transfer();
        6: begin
          n = $urandom_range(1, 6);
          repeat (n) send_random(bts_pkg::REQ_TICK);
        end
        7: send_random(bts_pkg::REQ_W'($urandom_range(0, 15)));
        8: begin
          send_random(bts_pkg::REQ_START_REF);
          send_random(bts_pkg::REQ_TICK);
          send_random(bts_pkg::REQ_TICK);
        end
        default: send_random(bts_pkg::REQ_CLEAR_EV);
      endcase
    end
  endtask

  // both registers, written back to back while the block is idle
  task automatic program_regs(input logic [bts_pkg::STALL_W-1:0] limit,
                              input logic [bts_pkg::CFG_W-1:0] tmo);
    cfg_valid <= 1'b1;
    cfg_index <= bts_pkg::CFG_STUCK_LIMIT;
    cfg_data  <= bts_pkg::CFG_W'(limit);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.set_reg(bts_pkg::CFG_STUCK_LIMIT, bts_pkg::CFG_W'(limit));
    cfg_index <= bts_pkg::CFG_BLK_TIMEOUT;
    cfg_data  <= tmo;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.set_reg(bts_pkg::CFG_BLK_TIMEOUT, tmo);
    cfg_valid <= 1'b0;
  endtask

  // stop offering, let every result arrive, then allow the pipeline to settle
  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // result side: random stall per result, one long hold-off mid-run
  initial begin
    report_t got;
    int      hold;
    wait (rst_n === 1'b1);
    forever begin
      hold = (got_count == 150) ? 90 : pick_wait(got_count + 7);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
      got.status         = out_status;
      got.accepted       = out_accepted;
      got.cmd_valid      = out_cmd_valid;
      got.cmd_kind       = out_cmd_kind;
      got.cmd_address    = out_cmd_address;
      got.cmd_length     = out_cmd_length;
      got.cmd_timeout    = out_cmd_timeout;
      got.watchdog_fired = out_watchdog_fired;
      got.state_now      = out_state_now;
      tracker.check_result(got);
      got_count++;
    end
  end

  // run limit
  initial begin
    #5_000_000;
    $display("bus_transfer_sequencer_tb: FAIL");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed flows under the widest limit and timeout
    program_regs(16'hFFFF, 32'hFFFF_FFFF);
    send_item(bts_pkg::REQ_BLK_READ, 7'h7F, 16'hFFFF, 16'hFFFF);  // refused while in init
    send_item(bts_pkg::REQ_DONE_ACK, 7'h00, 16'h0000, 16'h0000);  // ignored in init
    send_item(bts_pkg::REQ_TICK, 7'h00, 16'h0000, 16'h0000);      // reinit, idle with init done
    send_item(bts_pkg::REQ_TICK, 7'h7F, 16'hFFFF, 16'hFFFF);      // no row, stall counter runs
    send_item(bts_pkg::REQ_CLEAR_EV, 7'h00, 16'h0000, 16'h0000);
    send_item(bts_pkg::REQ_DMA_READ, 7'h7F, 16'hFFFF, 16'h0000);
    send_item(bts_pkg::REQ_DMA_WRITE, 7'h00, 16'h0000, 16'hFFFF); // overwrites the latched read
    send_item(bts_pkg::REQ_TICK, 7'h00, 16'h0000, 16'h0000);
    send_item(bts_pkg::REQ_DMA_READ, 7'h12, 16'h0034, 16'h0000);  // refused busy
    send_item(bts_pkg::REQ_DONE_ACK, 7'h00, 16'h0000, 16'h0000);
    send_item(bts_pkg::REQ_TICK, 7'h00, 16'h0000, 16'h0000);
    send_item(bts_pkg::REQ_DMA_WR_RD, 7'h55, 16'hAAAA, 16'h5555);
    send_item(bts_pkg::REQ_TICK, 7'h2A, 16'h5555, 16'hAAAA);
    send_item(bts_pkg::REQ_DONE_ACK, 7'h00, 16'h0000, 16'h0000);  // write part done
    send_item(bts_pkg::REQ_TICK, 7'h00, 16'h0000, 16'h0000);      // chains into the read
    send_item(bts_pkg::REQ_DONE_ACK, 7'h00, 16'h0000, 16'h0000);
    send_item(bts_pkg::REQ_TICK, 7'h00, 16'h0000, 16'h0000);
    send_item(bts_pkg::REQ_BLK_WRITE, 7'h7F, 16'hFFFF, 16'h0000);
    send_item(bts_pkg::REQ_TICK, 7'h00, 16'h0000, 16'h0000);
    send_item(bts_pkg::REQ_START_REF, 7'h00, 16'h0000, 16'h0000); // error in a transfer
    send_item(bts_pkg::REQ_TICK, 7'h00, 16'h0000, 16'h0000);      // error state
    send_item(bts_pkg::REQ_TICK, 7'h00, 16'h0000, 16'h0000);      // back to idle
    send_item(bts_pkg::REQ_START_REF, 7'h00, 16'h0000, 16'h0000); // error while idle
    send_item(bts_pkg::REQ_BLK_READ, 7'h01, 16'h0001, 16'h0000);
    send_item(bts_pkg::REQ_TICK, 7'h00, 16'h0000, 16'h0000);
    send_item(bts_pkg::REQ_W'(15), 7'h7F, 16'hFFFF, 16'hFFFF);    // unknown codes
    send_item(bts_pkg::REQ_W'(9), 7'h00, 16'h0000, 16'h0000);
    random_phase(100);
    drain();

    // lowered limit: the watchdog fires on the second tick with no table row since the stall counter last cleared
    program_regs(16'd1, 32'h0000_0000);
    random_phase(200);
    drain();

    program_regs(16'd3, $urandom);
    random_phase(300);
    drain();

    program_regs(bts_pkg::STUCK_LIMIT_RST, $urandom);
    random_phase(400);
    drain();

    program_regs(16'd2, 32'h8000_0001);
    random_phase(500);
    drain();

    if (tracker.failures == 0) $display("bus_transfer_sequencer_tb: PASS");
    else $display("bus_transfer_sequencer_tb: FAIL");
    $finish;
  end

endmodule
